// File: hw/rtl/ccrc_pkg.sv
// Package for the configurable CRC engine: register indexes, the configuration
// struct and helper functions for width and mask. No dependencies.
`default_nettype none

package ccrc_pkg;

    localparam int MAX_WIDTH = 32;
    localparam int CRC_W     = 32;

    typedef enum logic [2:0] {
        REG_WIDTH_MODE  = 3'd0,
        REG_POLY        = 3'd1,
        REG_INIT_VALUE  = 3'd2,
        REG_XOR_OUT     = 3'd3,
        REG_SHIFT_RIGHT = 3'd4
    } ccrc_reg_idx_t;

    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_32 = 2'd2
    } ccrc_width_t;

    typedef struct packed {
        logic [1:0]       width_mode;
        logic [CRC_W-1:0] poly;
        logic [CRC_W-1:0] init_value;
        logic [CRC_W-1:0] xor_out;
        logic             shift_right;
    } ccrc_cfg_t;

    // Active CRC width in bits; the unused code behaves as 32 bits.
    function automatic logic [5:0] width_bits(input logic [1:0] mode);
        int w;
        case (mode)
            WIDTH_8:  w = 8;
            WIDTH_16: w = 16;
            default:  w = 32;
        endcase
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (w < 8) w = 8;
        return 6'(w);
    endfunction

    function automatic logic [CRC_W-1:0] width_mask(input logic [5:0] w);
        logic [CRC_W-1:0] m;
        if (w >= 6'(CRC_W)) m = '1;
        else m = (CRC_W'(1) << w) - CRC_W'(1);
        return m;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ccrc_byte_step.sv
// Combinational absorption of one message byte into the CRC register.
// Depends on ccrc_pkg for the configuration struct and width helpers.
`default_nettype none

module ccrc_byte_step
    import ccrc_pkg::*;
(
    input  wire ccrc_cfg_t        cfg,
    input  wire logic [CRC_W-1:0] crc_in,
    input  wire logic [7:0]       data,
    output logic [CRC_W-1:0]      crc_out,
    output logic [CRC_W-1:0]      mask
);

    logic [5:0]       w;
    logic [4:0]       top_idx;
    logic [4:0]       shamt;
    logic [CRC_W-1:0] p;

    assign w       = width_bits(cfg.width_mode);
    assign mask    = width_mask(w);
    assign top_idx = 5'(w - 6'd1);
    assign shamt   = 5'(w - 6'd8);
    assign p       = cfg.poly & mask;

    // Eight bit steps, unrolled; each one is a shift and a conditional xor.
    always_comb
    begin
        logic [CRC_W-1:0] c;
        logic [CRC_W-1:0] shifted;
        logic             out_bit;
        c = crc_in & mask;
        if (cfg.shift_right)
        begin
            c = c ^ {{(CRC_W-8){1'b0}}, data};
        end
        else
        begin
            c = c ^ ({{(CRC_W-8){1'b0}}, data} << shamt);
        end
        for (int k = 0; k < 8; k++)
        begin
            if (cfg.shift_right)
            begin
                out_bit = c[0];
                shifted = c >> 1;
            end
            else
            begin
                out_bit = c[top_idx];
                shifted = (c << 1) & mask;
            end
            c = out_bit ? (shifted ^ p) : shifted;
        end
        crc_out = c & mask;
    end

endmodule

`default_nettype wire

// File: hw/rtl/configurable_crc_engine_top.sv
// Top level of the configurable CRC engine: configuration registers, input
// stage, running CRC register and result register. Uses ccrc_pkg, ccrc_byte_step.
`default_nettype none

// Usage
// The slave stream carries one message byte per item in s_axis_tdata, with
// s_axis_tlast marking the final byte of a message. For every last byte the
// master stream delivers one item: the CRC masked to the configured width and
// xored with the output mask, zero above the width. Other bytes produce no item.
// The configuration port writes one register per cycle while cfg_we is high:
// index 0 width mode, 1 polynomial, 2 init value, 3 output xor, 4 shift
// direction. Writes to other indexes are ignored. Registers should be changed
// only while no message bytes are in flight.
// Flow: a byte is captured in the input register; when it advances, the eight
// unrolled bit steps update the CRC register and, for a last byte, load the
// result register, which drives the master stream. One byte is accepted every
// cycle unless a last byte is held in the input register (see Stalls).
// Stalls: the result register holds its item until m_axis_tready. While it is
// full and m_axis_tready is low, a last byte waiting in the input register is held and
// s_axis_tready drops; plain bytes keep flowing since they produce no item.
// Reset: rst_n clears all valid flags, loads the register reset values
// (32-bit, polynomial 0x04C11DB7, init 0, output xor all ones, shift right)
// and clears the CRC register to zero.

module configurable_crc_engine_top
    import ccrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [31:0] cfg_wdata,
    // Slave stream. tdata fields from bit 0: data_byte[7:0]. tlast: last_byte.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,
    input  wire logic        s_axis_tlast,
    // Master stream. tdata fields from bit 0: crc_value[31:0].
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata
);

    ccrc_cfg_t        cfg_reg;

    logic             in_valid_reg;
    logic [7:0]       in_data_reg;
    logic             in_last_reg;

    logic [CRC_W-1:0] crc_reg;
    logic [CRC_W-1:0] crc_next;
    logic [CRC_W-1:0] mask;

    logic             out_valid_reg;
    logic [CRC_W-1:0] out_data_reg;

    logic             out_free;
    logic             stage_fire;
    logic             in_accept;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_mode  <= WIDTH_32;
            cfg_reg.poly        <= 32'h04C1_1DB7;
            cfg_reg.init_value  <= '0;
            cfg_reg.xor_out     <= '1;
            cfg_reg.shift_right <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_WIDTH_MODE:  cfg_reg.width_mode  <= cfg_wdata[1:0];
                REG_POLY:        cfg_reg.poly        <= cfg_wdata;
                REG_INIT_VALUE:  cfg_reg.init_value  <= cfg_wdata;
                REG_XOR_OUT:     cfg_reg.xor_out     <= cfg_wdata;
                REG_SHIFT_RIGHT: cfg_reg.shift_right <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // A plain byte always advances; a last byte needs room in the result
    // register, which is free when empty or being taken this cycle.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign stage_fire    = in_valid_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_valid_reg || stage_fire;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    ccrc_byte_step u_step (
        .cfg     (cfg_reg),
        .crc_in  (crc_reg),
        .data    (in_data_reg),
        .crc_out (crc_next),
        .mask    (mask)
    );

    // Running CRC: reloads the init value after the last byte of a message.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= '0;
        end
        else if (stage_fire)
        begin
            crc_reg <= in_last_reg ? (cfg_reg.init_value & mask) : crc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_fire && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_fire && in_last_reg)
        begin
            out_data_reg <= (crc_next ^ (cfg_reg.xor_out & mask)) & mask;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

// File: hw/rtl/ccrc_checker.sv
// Port-level checks for the configurable CRC engine, bound to the top level.
// Depends only on the top level's port names.
`default_nettype none

module ccrc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The input side only stalls behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back-pressure");

    // A new result out of an empty output follows an accepted last byte, through the input and result registers.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !$past(m_axis_tvalid)
        |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("result without a preceding last byte");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("result valid during reset");

endmodule

bind configurable_crc_engine_top ccrc_checker u_ccrc_checker (.*);

`default_nettype wire
